>>> design/bpc_pkg.sv
`default_nettype none

package bpc_pkg;

    // Fixed field widths
    localparam int MAX_BUTTONS = 8;
    localparam int IDX_W       = 3;
    localparam int TIME_W      = 16;
    localparam int MASK_W      = 8;

    // Defaults for the top-level parameters
    localparam int NUM_BUTTONS_DEF = 8;
    localparam int SCAN_STEP_DEF   = 10;

    // Depth of the queue between classifier and event sequencer
    localparam int QUEUE_DEPTH = 2;

    // Register reset values
    localparam logic [TIME_W-1:0] DEBOUNCE_RST = 16'd20;
    localparam logic [TIME_W-1:0] LONG_RST     = 16'd1000;
    localparam logic [MASK_W-1:0] ACTIVE_RST   = 8'h00;
    localparam logic [MASK_W-1:0] ENABLED_RST  = 8'hFF;

    // Event kinds as they appear on the output
    typedef enum logic [1:0] {
        EV_SHORT        = 2'd0,
        EV_LONG         = 2'd1,
        EV_LONG_RELEASE = 2'd2
    } ev_kind_t;

    // Register indexes (paddr[3:2])
    typedef enum logic [1:0] {
        REG_DEBOUNCE = 2'd0,
        REG_LONG     = 2'd1,
        REG_ACTIVE   = 2'd2,
        REG_ENABLED  = 2'd3
    } reg_idx_t;

    // Configuration seen by the classifier
    typedef struct packed {
        logic [TIME_W-1:0] debounce_time;
        logic [TIME_W-1:0] long_press_time;
        logic [MASK_W-1:0] active_level_mask;
        logic [MASK_W-1:0] enabled_mask;
    } cfg_t;

    // Events caused by one scan tick, one slot per button
    typedef struct packed {
        logic     [MAX_BUTTONS-1:0] hit;
        ev_kind_t [MAX_BUTTONS-1:0] kind;
    } rec_t;

endpackage

`default_nettype wire

>>> design/bpc_front.sv
`default_nettype none

module bpc_front #(
    parameter int NUM_BUTTONS = bpc_pkg::NUM_BUTTONS_DEF,
    parameter int SCAN_STEP   = bpc_pkg::SCAN_STEP_DEF
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire bpc_pkg::cfg_t              cfg,
    input  wire logic [bpc_pkg::MASK_W-1:0] levels,
    input  wire logic                       accept,
    output logic                            push,
    output bpc_pkg::rec_t                   rec
);

    localparam int SUM_W = bpc_pkg::TIME_W + 1;

    logic [bpc_pkg::TIME_W-1:0] held_reg  [NUM_BUTTONS];
    logic [bpc_pkg::TIME_W-1:0] held_next [NUM_BUTTONS];
    logic [NUM_BUTTONS-1:0]     latch_reg;
    logic [NUM_BUTTONS-1:0]     latch_next;

    // Per-button classification, all lanes side by side
    always_comb
    begin
        logic [SUM_W-1:0]          sum;
        logic [bpc_pkg::TIME_W-1:0] sat;
        logic                      pressed;
        rec = '0;
        for (int b = 0; b < NUM_BUTTONS; b++)
        begin
            held_next[b]  = held_reg[b];
            latch_next[b] = latch_reg[b];
            sum     = {1'b0, held_reg[b]} + SUM_W'(SCAN_STEP);
            sat     = sum[SUM_W-1] ? '1 : sum[bpc_pkg::TIME_W-1:0];
            pressed = ~(levels[b] ^ cfg.active_level_mask[b]);
            if (cfg.enabled_mask[b])
            begin
                if (pressed)
                begin
                    held_next[b] = sat;
                    if (!latch_reg[b] && (sat > cfg.long_press_time))
                    begin
                        rec.hit[b]    = 1'b1;
                        rec.kind[b]   = bpc_pkg::EV_LONG;
                        latch_next[b] = 1'b1;
                    end
                end
                else
                begin
                    if (held_reg[b] > cfg.debounce_time)
                    begin
                        rec.hit[b]  = 1'b1;
                        rec.kind[b] = (held_reg[b] <= cfg.long_press_time) ?
                                      bpc_pkg::EV_SHORT : bpc_pkg::EV_LONG_RELEASE;
                    end
                    held_next[b]  = '0;
                    latch_next[b] = 1'b0;
                end
            end
        end
    end

    // Ticks without events never enter the queue
    assign push = accept && (rec.hit != '0);

    // Held times and latches
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int b = 0; b < NUM_BUTTONS; b++)
            begin
                held_reg[b] <= '0;
            end
            latch_reg <= '0;
        end
        else if (accept)
        begin
            for (int b = 0; b < NUM_BUTTONS; b++)
            begin
                held_reg[b] <= held_next[b];
            end
            latch_reg <= latch_next;
        end
    end

endmodule

`default_nettype wire

>>> design/bpc_queue.sv
`default_nettype none

module bpc_queue #(
    parameter int DEPTH = bpc_pkg::QUEUE_DEPTH
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire bpc_pkg::rec_t push_rec,
    input  wire logic          pop,
    output logic               full,
    output logic               not_empty,
    output bpc_pkg::rec_t      head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    bpc_pkg::rec_t    slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_pop;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = slot_reg[rd_ptr_reg];
    assign do_pop    = pop && not_empty;

    // Storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_rec;
        end
    end

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

>>> design/bpc_back.sv
`default_nettype none

module bpc_back (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          q_not_empty,
    input  wire bpc_pkg::rec_t q_head,
    output logic               q_pop,
    output logic               m_tvalid,
    input  wire logic          m_tready,
    output logic [7:0]         m_tdata,
    output logic               m_tlast
);

    bpc_pkg::rec_t                   pend_reg;
    bpc_pkg::rec_t                   pend_next;
    logic [bpc_pkg::MAX_BUTTONS-1:0] rem;
    logic [bpc_pkg::IDX_W-1:0]       sel;
    logic                            out_free;
    logic                            emit;
    logic                            valid_reg;
    logic [bpc_pkg::IDX_W-1:0]       idx_reg;
    bpc_pkg::ev_kind_t               kind_reg;
    logic                            last_reg;

    // Lowest pending button
    always_comb
    begin
        sel = '0;
        for (int b = bpc_pkg::MAX_BUTTONS - 1; b >= 0; b--)
        begin
            if (pend_reg.hit[b])
            begin
                sel = bpc_pkg::IDX_W'(b);
            end
        end
    end

    assign rem      = pend_reg.hit & (pend_reg.hit - 1'b1);
    assign out_free = !valid_reg || m_tready;
    assign emit     = out_free && (pend_reg.hit != '0);
    assign q_pop    = (pend_reg.hit == '0) || (emit && (rem == '0));

    // Next working record
    always_comb
    begin
        pend_next = pend_reg;
        if (emit)
        begin
            pend_next.hit = rem;
        end
        if (q_pop && q_not_empty)
        begin
            pend_next = q_head;
        end
    end

    // Working record
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
        end
        else
        begin
            pend_reg <= pend_next;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            valid_reg <= emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            idx_reg  <= sel;
            kind_reg <= pend_reg.kind[sel];
            last_reg <= (rem == '0);
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {3'b000, kind_reg, idx_reg};
    assign m_tlast  = last_reg;

endmodule

`default_nettype wire

>>> design/button_press_classifier_unit.sv
// Button press classifier.
// Slave stream: one transfer per scan tick, s_tdata bit i is the raw level
// of button i. Master stream: one transfer per event; m_tdata carries the
// button index and the event kind (short, long reached, long released),
// m_tlast marks the final event of a tick. Ticks that cause no event
// produce no output at all.
// APB port: debounce time (0x0), long-press time (0x4), active level mask
// (0x8), enable mask (0xC); write only while the stream is idle.
// The first event of a tick passes the event queue, the working record and
// the output register; more events of the same tick follow one per cycle
// while m_tready is high. A tick is taken every cycle while the two-entry
// event queue has room; the sequencer emits the events of a tick one after
// another, so the sustained tick rate is set by the sequencer.
// Reset clears held times and latches and loads register defaults.
// When m_tready is low the output holds its event; the queue then fills and
// s_tready drops once it is full.
`default_nettype none

module button_press_classifier_unit #(
    parameter int NUM_BUTTONS = bpc_pkg::NUM_BUTTONS_DEF,
    parameter int SCAN_STEP   = bpc_pkg::SCAN_STEP_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // slave stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] button_levels
    // master stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // [2:0] button_index, [4:3] event_kind, [7:5] zero
    output logic             m_tlast,   // last_event
    // configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    bpc_pkg::cfg_t     cfg_reg;
    bpc_pkg::reg_idx_t reg_idx;
    logic              wr_en;
    logic              accept;
    logic              push;
    bpc_pkg::rec_t     push_rec;
    logic              q_full;
    logic              q_not_empty;
    logic              q_pop;
    bpc_pkg::rec_t     q_head;

    assign pready  = 1'b1;
    assign reg_idx = bpc_pkg::reg_idx_t'(paddr[3:2]);
    assign wr_en   = psel && penable && pwrite && pready;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.debounce_time     <= bpc_pkg::DEBOUNCE_RST;
            cfg_reg.long_press_time   <= bpc_pkg::LONG_RST;
            cfg_reg.active_level_mask <= bpc_pkg::ACTIVE_RST;
            cfg_reg.enabled_mask      <= bpc_pkg::ENABLED_RST;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                bpc_pkg::REG_DEBOUNCE: cfg_reg.debounce_time     <= pwdata[15:0];
                bpc_pkg::REG_LONG:     cfg_reg.long_press_time   <= pwdata[15:0];
                bpc_pkg::REG_ACTIVE:   cfg_reg.active_level_mask <= pwdata[7:0];
                bpc_pkg::REG_ENABLED:  cfg_reg.enabled_mask      <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    // Register read back
    always_comb
    begin
        case (reg_idx)
            bpc_pkg::REG_DEBOUNCE: prdata = {16'h0000, cfg_reg.debounce_time};
            bpc_pkg::REG_LONG:     prdata = {16'h0000, cfg_reg.long_press_time};
            bpc_pkg::REG_ACTIVE:   prdata = {24'h000000, cfg_reg.active_level_mask};
            bpc_pkg::REG_ENABLED:  prdata = {24'h000000, cfg_reg.enabled_mask};
            default:               prdata = '0;
        endcase
    end

    // Tick intake
    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;

    bpc_front #(
        .NUM_BUTTONS (NUM_BUTTONS),
        .SCAN_STEP   (SCAN_STEP)
    ) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_reg),
        .levels (s_tdata),
        .accept (accept),
        .push   (push),
        .rec    (push_rec)
    );

    bpc_queue #(
        .DEPTH (bpc_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_rec  (push_rec),
        .pop       (q_pop),
        .full      (q_full),
        .not_empty (q_not_empty),
        .head      (q_head)
    );

    bpc_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_not_empty (q_not_empty),
        .q_head      (q_head),
        .q_pop       (q_pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast)
    );

endmodule

`default_nettype wire

>>> design/bpc_checker.sv
`default_nettype none

module bpc_checker #(
    parameter int NUM_BUTTONS = bpc_pkg::NUM_BUTTONS_DEF
) (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       m_tvalid,
    input wire logic       m_tready,
    input wire logic [7:0] m_tdata,
    input wire logic       m_tlast
);

    // A stalled event holds
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output event changed while stalled");

    // Only the three defined event kinds
    a_kind: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[4:3] != 2'd3))
        else $error("undefined event kind");

    // Padding bits stay zero
    a_pad: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[7:5] == 3'b000))
        else $error("nonzero padding in m_tdata");

    // Events only name scanned buttons
    a_index: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (32'(m_tdata[2:0]) < NUM_BUTTONS))
        else $error("button index out of range");

endmodule

bind button_press_classifier_unit bpc_checker #(
    .NUM_BUTTONS (NUM_BUTTONS)
) u_bpc_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

`default_nettype wire
